// ===== hw/rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants, types and helpers for the four-level page table walker.
// ----------------------------------------------------------------------------
package fpt_pkg;

   // Table store geometry.
   localparam int TABLE_COUNT       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int TABLE_W           = $clog2(TABLE_COUNT);
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int ADDR_W            = TABLE_W + IDX_W;
   localparam int STORE_DEPTH       = TABLE_COUNT * ENTRIES_PER_TABLE;
   localparam int FREE_W            = $clog2(TABLE_COUNT + 1);
   localparam int ENTRY_W           = 64;

   // Transaction field widths.
   localparam int KIND_W  = 2;
   localparam int VA_W    = 48;
   localparam int PA_W    = 52;
   localparam int FLAGS_W = 64;

   // Request kinds.
   localparam logic [KIND_W-1:0] REQ_MAP       = 2'd0;
   localparam logic [KIND_W-1:0] REQ_UNMAP     = 2'd1;
   localparam logic [KIND_W-1:0] REQ_TRANSLATE = 2'd2;

   // Entry layout.
   localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h0000_0000_0000_0001;
   localparam logic [ENTRY_W-1:0] INNER_FLAGS = 64'h0000_0000_0000_0007;
   localparam int                 PAGE_SHIFT  = 12;
   localparam int                 FRAME_W     = PA_W - PAGE_SHIFT;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } walk_state_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } store_wr_type;

   // Nine-bit table index for one level of the walk, root level first.
   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0]      level);
      logic [IDX_W-1:0] idx;
      unique case (level)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== hw/rtl/fpt_channels.sv =====
// ----------------------------------------------------------------------------
// fpt_channels
// Valid/ready channel interfaces for walker requests and responses.
// ----------------------------------------------------------------------------
interface fpt_req_if;
   logic                          valid;
   logic                          ready;
   logic [fpt_pkg::KIND_W-1:0]    req_type;
   logic [fpt_pkg::VA_W-1:0]      virt_addr;
   logic [fpt_pkg::PA_W-1:0]      phys_addr;
   logic [fpt_pkg::FLAGS_W-1:0]   leaf_flags;

   modport source (output valid, req_type, virt_addr, phys_addr, leaf_flags,
                   input ready);
   modport sink   (input valid, req_type, virt_addr, phys_addr, leaf_flags,
                   output ready);
endinterface

interface fpt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fpt_pkg::PA_W-1:0]  result_addr;
   logic                      was_mapped;
   logic                      status;

   modport source (output valid, result_addr, was_mapped, status, input ready);
   modport sink   (input valid, result_addr, was_mapped, status, output ready);
endinterface

// ===== hw/rtl/fpt_store.sv =====
// ----------------------------------------------------------------------------
// fpt_store
// Single-port-write, single-port-read table store with a registered read.
// ----------------------------------------------------------------------------
module fpt_store (
   input  logic                           clock,
   input  fpt_pkg::store_wr_type          wr,
   input  logic                           rd_en,
   input  logic [fpt_pkg::ADDR_W-1:0]     rd_addr,
   output logic [fpt_pkg::ENTRY_W-1:0]    rd_data
);
   import fpt_pkg::*;

   logic [ENTRY_W-1:0] mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/four_level_page_table_map_walk.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk
// Four-level radix page table: map with table allocation, unmap, translate.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Carries
//   req_chan   in         req_type, virt_addr, phys_addr, leaf_flags
//   rsp_chan   out        result_addr, was_mapped, status (one per request)
//
// One request is walked at a time. Each level has a read state and an
// evaluate state of the table store, whose read data is registered; a map
// writes its leaf without reading it, and an unknown request type goes
// straight to its response without a walk.
// After reset the store is swept to zero, one entry a cycle, through all
// TABLE_COUNT * 512 entries (32768 here); no request is accepted meanwhile.
// A completed response sits in an output register, so a new request is
// accepted while the previous response waits for the sink.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk (
   input  logic        clock,
   input  logic        reset,
   fpt_req_if.sink     req_chan,
   fpt_rsp_if.source   rsp_chan
);
   import fpt_pkg::*;

   // Walk state.
   walk_state_type      state_ff,   state_in;
   logic [1:0]          level_ff,   level_in;
   logic [TABLE_W-1:0]  tbl_ff,     tbl_in;
   logic [ADDR_W-1:0]   addr_ff,    addr_in;
   logic [FREE_W-1:0]   free_ff,    free_in;
   logic [ADDR_W-1:0]   clr_ff,     clr_in;

   // The request being walked; captured on acceptance.
   logic [KIND_W-1:0]   kind_ff;
   logic [VA_W-1:0]     va_ff;
   logic [PA_W-1:0]     pa_ff;
   logic [FLAGS_W-1:0]  flags_ff;

   // Result being built, and the output register.
   logic [PA_W-1:0]     res_addr_ff, res_addr_in;
   logic                res_map_ff,  res_map_in;
   logic                res_stat_ff, res_stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]     rsp_addr_ff;
   logic                rsp_map_ff;
   logic                rsp_stat_ff;
   logic                rsp_load;

   // Table store port.
   store_wr_type        wr;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_data;

   logic                accept;
   logic                slot_free;
   logic                ent_present;
   logic                ent_in_store;
   logic [TABLE_W-1:0]  ent_tbl;
   logic                pool_empty;
   logic [ENTRY_W-1:0]  alloc_entry;
   logic [ENTRY_W-1:0]  leaf_entry;

   fpt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Decode of the entry just read. A non-leaf entry is followed only when
   // it is present and names a table inside the store.
   assign ent_present  = rd_data[0];
   assign ent_in_store = rd_data[PA_W-1:PAGE_SHIFT] < FRAME_W'(TABLE_COUNT);
   assign ent_tbl      = rd_data[PAGE_SHIFT +: TABLE_W];
   assign pool_empty   = free_ff >= FREE_W'(TABLE_COUNT);

   // A freshly allocated table is linked in with present, writable and user.
   assign alloc_entry = (ENTRY_W'(free_ff[TABLE_W-1:0]) << PAGE_SHIFT) | INNER_FLAGS;
   assign leaf_entry  = ENTRY_W'({pa_ff[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}})
                        | flags_ff | BIT_PRESENT;

   assign rd_addr = {tbl_ff, level_index(va_ff, level_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      level_in    = level_ff;
      tbl_in      = tbl_ff;
      addr_in     = addr_ff;
      free_in     = free_ff;
      clr_in      = clr_ff;
      res_addr_in = res_addr_ff;
      res_map_in  = res_map_ff;
      res_stat_in = res_stat_ff;
      wr          = '0;
      rd_en       = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero the whole store once after reset.
            wr.en   = 1'b1;
            wr.addr = clr_ff;
            wr.data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               level_in    = 2'd0;
               tbl_in      = '0;
               res_addr_in = '0;
               res_map_in  = 1'b0;
               res_stat_in = 1'b0;
               if (req_chan.req_type == REQ_MAP || req_chan.req_type == REQ_UNMAP ||
                   req_chan.req_type == REQ_TRANSLATE) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_READ: begin
            addr_in = rd_addr;
            if (level_ff == 2'd3 && kind_ff == REQ_MAP) begin
               // The leaf of a map is written blind.
               wr.en    = 1'b1;
               wr.addr  = rd_addr;
               wr.data  = leaf_entry;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (level_ff != 2'd3) begin
               if (kind_ff == REQ_MAP && !ent_present) begin
                  if (pool_empty) begin
                     res_stat_in = 1'b1;
                     state_in    = ST_DONE;
                  end else begin
                     wr.en    = 1'b1;
                     wr.addr  = addr_ff;
                     wr.data  = alloc_entry;
                     tbl_in   = free_ff[TABLE_W-1:0];
                     free_in  = free_ff + 1'b1;
                     level_in = level_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end else if (ent_present && ent_in_store) begin
                  tbl_in   = ent_tbl;
                  level_in = level_ff + 1'b1;
                  state_in = ST_READ;
               end else begin
                  res_stat_in = (kind_ff == REQ_MAP);
                  state_in    = ST_DONE;
               end
            end else begin
               // Leaf level: only unmap and translate read the leaf.
               if (kind_ff == REQ_UNMAP) begin
                  wr.en   = 1'b1;
                  wr.addr = addr_ff;
                  wr.data = '0;
               end else if (ent_present) begin
                  res_addr_in = {rd_data[PA_W-1:PAGE_SHIFT], va_ff[PAGE_SHIFT-1:0]};
                  res_map_in  = 1'b1;
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= FREE_W'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      tbl_ff      <= tbl_in;
      addr_ff     <= addr_in;
      res_addr_ff <= res_addr_in;
      res_map_ff  <= res_map_in;
      res_stat_ff <= res_stat_in;
      if (accept) begin
         kind_ff  <= req_chan.req_type;
         va_ff    <= req_chan.virt_addr;
         pa_ff    <= req_chan.phys_addr;
         flags_ff <= req_chan.leaf_flags;
      end
      if (rsp_load) begin
         rsp_addr_ff <= res_addr_ff;
         rsp_map_ff  <= res_map_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_addr = rsp_addr_ff;
   assign rsp_chan.was_mapped  = rsp_map_ff;
   assign rsp_chan.status      = rsp_stat_ff;

   // The pool pointer stays between the root and one past the last table.
   a_free_range : assert property (@(posedge clock) disable iff (reset)
      (free_ff >= FREE_W'(1)) && (free_ff <= FREE_W'(TABLE_COUNT)))
      else $error("table pool pointer out of range");

   // Only a map request can take a table from the pool.
   a_alloc_on_map : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && free_ff != $past(free_ff)) |-> $past(kind_ff == REQ_MAP))
      else $error("table allocated outside a map request");

   // A response appears only as a walk completes.
   a_rsp_after_walk : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised without a completed walk");

   // The store is never written while the walker waits for a request.
   a_no_idle_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr.en)
      else $error("table store written while idle");

endmodule
